>>> hw/rtl/ndic_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ndic_pkg
// Shared widths, reset values, register codes and the word types that move
// through the normalized difference index colour pipeline.
// ----------------------------------------------------------------------------
package ndic_pkg;

    localparam int SAMPLE_W        = 16;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int MAX_SAMPLE_BITS = 16;
    localparam int OFFSET_W        = 16;
    localparam int CUT_W           = 15;
    localparam int FRAC_W          = 14;
    localparam int QUO_W           = 16;
    localparam int IDX_W           = 16;
    localparam int DEN_W           = MAX_SAMPLE_BITS + 1;
    localparam int REM_W           = MAX_SAMPLE_BITS + FRAC_W;
    localparam int WIDE_W          = DEN_W + QUO_W;
    localparam int BYTE_W          = 8;
    localparam int ADDR_W          = 4;
    localparam int DATA_W          = 32;
    localparam int BASE_W          = IDX_W + 1;
    localparam int PROD_W          = BASE_W + 7;
    localparam int COL_W           = PROD_W - FRAC_W;

    localparam logic                RST_MODE      = 1'b0;
    localparam logic [OFFSET_W-1:0] RST_OFFSET    = 16'd1000;
    localparam logic [CUT_W-1:0]    RST_VEG_CUT   = 15'd9830;
    localparam logic [CUT_W-1:0]    RST_WATER_CUT = 15'd0;

    localparam logic signed [IDX_W-1:0]  IDX_MAX       = 16'sh7FFF;
    localparam logic signed [IDX_W-1:0]  IDX_MIN       = 16'sh8000;
    localparam logic signed [IDX_W-1:0]  IDX_MINUS_ONE = 16'shC000;
    localparam logic [QUO_W-1:0]         POS_LIMIT     = 16'd32767;
    localparam logic [QUO_W-1:0]         NEG_LIMIT     = 16'd32768;
    localparam logic signed [BASE_W-1:0] Q_ONE         = 17'sd16384;
    localparam logic signed [PROD_W-1:0] COLOUR_SCALE  = 24'sd127;
    localparam logic [COL_W-1:0]         COLOUR_MAX    = 10'd254;

    typedef enum logic [1:0] {
        REG_MODE      = 2'd0,
        REG_OFFSET    = 2'd1,
        REG_VEG_CUT   = 2'd2,
        REG_WATER_CUT = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic                mode;
        logic [OFFSET_W-1:0] offset;
        logic [CUT_W-1:0]    veg_cut;
        logic [CUT_W-1:0]    water_cut;
    } cfg_t;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [DEN_W-1:0] den;
        logic [QUO_W-1:0] quo;
        logic             neg;
        logic             zero;
        logic             ovf;
        logic             last;
    } div_word_t;

endpackage

>>> hw/rtl/ndic_pix_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ndic_pix_if
// Pixel input channel: two band samples and the end-of-area flag.
// ----------------------------------------------------------------------------
interface ndic_pix_if;

    logic                          valid;
    logic                          ready;
    logic [ndic_pkg::SAMPLE_W-1:0] band_a;
    logic [ndic_pkg::SAMPLE_W-1:0] band_b;
    logic                          last_in;

    modport source (output valid, output band_a, output band_b, output last_in, input ready);
    modport sink   (input valid, input band_a, input band_b, input last_in, output ready);

endinterface

>>> hw/rtl/ndic_rgb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ndic_rgb_if
// Colour output channel: three colour bytes and the end-of-area flag.
// ----------------------------------------------------------------------------
interface ndic_rgb_if;

    logic                        valid;
    logic                        ready;
    logic [ndic_pkg::BYTE_W-1:0] red_byte;
    logic [ndic_pkg::BYTE_W-1:0] green_byte;
    logic [ndic_pkg::BYTE_W-1:0] blue_byte;
    logic                        last_out;

    modport source (output valid, output red_byte, output green_byte, output blue_byte,
                    output last_out, input ready);
    modport sink   (input valid, input red_byte, input green_byte, input blue_byte,
                    input last_out, output ready);

endinterface

>>> hw/rtl/normalized_difference_index_colour.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// normalized_difference_index_colour
// Maps each pixel's normalized difference index (A-B)/(A+B-2*offset) to an
// RGB colour word, vegetation index into green or water index into blue.
// ----------------------------------------------------------------------------
// Takes one pixel word per clock while the colour side takes its words and
// returns one colour word per pixel, in order: a front cell forms the
// numerator and denominator, a chain of 16 division cells that each settle one
// quotient bit, and an output cell saturates the index, scales it to a colour
// and routes it. Every cell holds its own word and stalls only when the cell
// after it is full, so back-pressure on the colour side stops the chain cell
// by cell. Configuration registers sit on the APB port at byte addresses 0x0
// (mode), 0x4 (radiometric offset), 0x8 (vegetation cut) and 0xC (water cut);
// write them only while no pixel is in flight.
// ----------------------------------------------------------------------------
module normalized_difference_index_colour #(
    parameter int SAMPLE_BITS = ndic_pkg::SAMPLE_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    ndic_pix_if.sink                    pix,
    ndic_rgb_if.source                  rgb,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ndic_pkg::ADDR_W-1:0] paddr,
    input  logic [ndic_pkg::DATA_W-1:0] pwdata,
    output logic [ndic_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import ndic_pkg::*;

    cfg_t      cfg;
    logic      chain_valid [0:QUO_W];
    logic      chain_ready [0:QUO_W];
    div_word_t chain_word  [0:QUO_W];

    ndic_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ndic_prep #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix       (pix),
        .offset    (cfg.offset),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[0]),
        .out_word  (chain_word[0])
    );

    // most significant quotient bit first
    for (genvar i = 0; i < QUO_W; i++)
    begin : g_cell
        ndic_div_cell #(
            .BIT (QUO_W - 1 - i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_word   (chain_word[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_word  (chain_word[i+1])
        );
    end

    ndic_colour u_colour (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (chain_valid[QUO_W]),
        .in_ready (chain_ready[QUO_W]),
        .in_word  (chain_word[QUO_W]),
        .cfg      (cfg),
        .rgb      (rgb)
    );

endmodule

>>> hw/rtl/ndic_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ndic_regs
// APB configuration registers: index mode, radiometric offset and the two
// index cuts.
// ----------------------------------------------------------------------------
module ndic_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ndic_pkg::ADDR_W-1:0]   paddr,
    input  logic [ndic_pkg::DATA_W-1:0]   pwdata,
    output logic [ndic_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output ndic_pkg::cfg_t                cfg
);
    import ndic_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t sel;
    logic     wr_en;

    assign pready = 1'b1;
    assign sel    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (sel)
                REG_MODE:      cfg_next.mode      = pwdata[0];
                REG_OFFSET:    cfg_next.offset    = pwdata[OFFSET_W-1:0];
                REG_VEG_CUT:   cfg_next.veg_cut   = pwdata[CUT_W-1:0];
                REG_WATER_CUT: cfg_next.water_cut = pwdata[CUT_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (sel)
            REG_MODE:      prdata = DATA_W'(cfg_reg.mode);
            REG_OFFSET:    prdata = DATA_W'(cfg_reg.offset);
            REG_VEG_CUT:   prdata = DATA_W'(cfg_reg.veg_cut);
            REG_WATER_CUT: prdata = DATA_W'(cfg_reg.water_cut);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode      <= RST_MODE;
            cfg_reg.offset    <= RST_OFFSET;
            cfg_reg.veg_cut   <= RST_VEG_CUT;
            cfg_reg.water_cut <= RST_WATER_CUT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> hw/rtl/ndic_prep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ndic_prep
// Head cell of the divider chain: forms numerator and denominator, takes
// their magnitudes and flags zero denominator and quotient overflow.
// ----------------------------------------------------------------------------
module ndic_prep #(
    parameter int SAMPLE_BITS = ndic_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    ndic_pix_if.sink                      pix,
    input  logic [ndic_pkg::OFFSET_W-1:0] offset,
    output logic                          out_valid,
    input  logic                          out_ready,
    output ndic_pkg::div_word_t           out_word
);
    import ndic_pkg::*;

    localparam int DS_W = DEN_W + 2;

    logic [SAMPLE_BITS-1:0]        a;
    logic [SAMPLE_BITS-1:0]        b;
    logic signed [SAMPLE_BITS:0]   num_s;
    logic signed [DS_W-1:0]        den_s;
    logic [SAMPLE_BITS-1:0]        num_mag;
    logic [DEN_W-1:0]              den_mag;
    logic [REM_W-1:0]              dividend;
    div_word_t                     word_next;
    div_word_t                     word_reg;
    logic                          valid_reg;
    logic                          valid_next;
    logic                          take;

    assign a     = pix.band_a[SAMPLE_BITS-1:0];
    assign b     = pix.band_b[SAMPLE_BITS-1:0];
    assign num_s = $signed({1'b0, a}) - $signed({1'b0, b});
    assign den_s = $signed(DS_W'(a)) + $signed(DS_W'(b)) - $signed(DS_W'(offset) << 1);

    assign num_mag  = num_s[SAMPLE_BITS] ? SAMPLE_BITS'(-num_s) : num_s[SAMPLE_BITS-1:0];
    assign den_mag  = den_s[DS_W-1] ? DEN_W'(-den_s) : DEN_W'(den_s);
    assign dividend = REM_W'(num_mag) << FRAC_W;

    always_comb
    begin
        word_next.rem  = dividend;
        word_next.den  = den_mag;
        word_next.quo  = '0;
        word_next.neg  = num_s[SAMPLE_BITS] ^ den_s[DS_W-1];
        word_next.zero = (den_s == '0);
        word_next.ovf  = WIDE_W'(dividend) >= (WIDE_W'(den_mag) << QUO_W);
        word_next.last = pix.last_in;
    end

    assign pix.ready  = !valid_reg || out_ready;
    assign take       = pix.valid && pix.ready;
    assign valid_next = pix.ready ? pix.valid : valid_reg;
    assign out_valid  = valid_reg;
    assign out_word   = word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            word_reg <= word_next;
        end
    end

endmodule

>>> hw/rtl/ndic_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ndic_div_cell
// One restoring division cell: decides one quotient bit and hands the
// partial remainder to the next cell.
// ----------------------------------------------------------------------------
module ndic_div_cell #(
    parameter int BIT = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  ndic_pkg::div_word_t in_word,
    output logic                out_valid,
    input  logic                out_ready,
    output ndic_pkg::div_word_t out_word
);
    import ndic_pkg::*;

    logic [WIDE_W-1:0] shifted;
    logic [WIDE_W-1:0] rem_ext;
    logic              ge;
    div_word_t         word_next;
    div_word_t         word_reg;
    logic              valid_reg;
    logic              valid_next;
    logic              take;

    assign shifted = WIDE_W'(in_word.den) << BIT;
    assign rem_ext = WIDE_W'(in_word.rem);
    assign ge      = rem_ext >= shifted;

    always_comb
    begin
        word_next          = in_word;
        word_next.rem      = ge ? REM_W'(rem_ext - shifted) : in_word.rem;
        word_next.quo[BIT] = ge;
    end

    assign in_ready   = !valid_reg || out_ready;
    assign take       = in_valid && in_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;
    assign out_valid  = valid_reg;
    assign out_word   = word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            word_reg <= word_next;
        end
    end

endmodule

>>> hw/rtl/ndic_colour.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ndic_colour
// Tail cell: signs and saturates the quotient, maps the index to a colour
// value, routes it by mode and cut, and holds the output word.
// ----------------------------------------------------------------------------
module ndic_colour (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  ndic_pkg::div_word_t in_word,
    input  ndic_pkg::cfg_t      cfg,
    ndic_rgb_if.source          rgb
);
    import ndic_pkg::*;

    logic signed [IDX_W-1:0]  idx;
    logic signed [IDX_W-1:0]  cut;
    logic signed [BASE_W-1:0] base;
    logic signed [PROD_W-1:0] prod;
    logic [COL_W-1:0]         col;
    logic [BYTE_W-1:0]        val;
    logic                     above;
    logic [BYTE_W-1:0]        on_val;
    logic [BYTE_W-1:0]        off_val;
    logic [BYTE_W-1:0]        red_next;
    logic [BYTE_W-1:0]        green_next;
    logic [BYTE_W-1:0]        blue_next;
    logic [BYTE_W-1:0]        red_reg;
    logic [BYTE_W-1:0]        green_reg;
    logic [BYTE_W-1:0]        blue_reg;
    logic                     last_reg;
    logic                     valid_reg;
    logic                     valid_next;
    logic                     take;

    // signed, saturated index
    always_comb
    begin
        if (in_word.zero)
        begin
            idx = IDX_MINUS_ONE;
        end
        else if (!in_word.neg)
        begin
            idx = (in_word.ovf || in_word.quo > POS_LIMIT) ? IDX_MAX : $signed(in_word.quo);
        end
        else
        begin
            idx = (in_word.ovf || in_word.quo > NEG_LIMIT) ? IDX_MIN : -$signed(in_word.quo);
        end
    end

    assign base = Q_ONE + $signed({idx[IDX_W-1], idx});
    assign prod = $signed({{(PROD_W-BASE_W){base[BASE_W-1]}}, base}) * COLOUR_SCALE;
    assign col  = prod[PROD_W-1:FRAC_W];

    always_comb
    begin
        if (prod[PROD_W-1])
        begin
            val = '0;
        end
        else if (col > COLOUR_MAX)
        begin
            val = BYTE_W'(COLOUR_MAX);
        end
        else
        begin
            val = col[BYTE_W-1:0];
        end
    end

    assign cut     = cfg.mode ? $signed({cfg.water_cut[CUT_W-1], cfg.water_cut})
                              : $signed({cfg.veg_cut[CUT_W-1], cfg.veg_cut});
    assign above   = idx > cut;
    assign on_val  = above ? val : '0;
    assign off_val = above ? '0 : val;

    // index channel is green in vegetation mode, blue in water mode
    assign red_next   = off_val;
    assign green_next = cfg.mode ? off_val : on_val;
    assign blue_next  = cfg.mode ? on_val : off_val;

    assign in_ready   = !valid_reg || rgb.ready;
    assign take       = in_valid && in_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    assign rgb.valid      = valid_reg;
    assign rgb.red_byte   = red_reg;
    assign rgb.green_byte = green_reg;
    assign rgb.blue_byte  = blue_reg;
    assign rgb.last_out   = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
            last_reg  <= in_word.last;
        end
    end

endmodule
